FILE: design/grid_line_of_sight_macros.svh
// Assertion macros for the line-of-sight block.
`ifndef GRID_LINE_OF_SIGHT_MACROS_SVH
`define GRID_LINE_OF_SIGHT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define GLOS_AIMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("glos: implication failed");
// Next-cycle implication.
`define GLOS_ANXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("glos: next-cycle implication failed");
`else
`define GLOS_AIMP(lbl, ante, cons)
`define GLOS_ANXT(lbl, ante, cons)
`endif
`endif

FILE: design/glos_pkg.sv
// Shared constants and controller/datapath interface types.
package glos_pkg;

  localparam int unsigned MapRowsDef = 64;
  localparam int unsigned MapColsDef = 256;

  localparam int unsigned RowW = 6;   // row field width
  localparam int unsigned ColW = 8;   // column field width
  localparam int unsigned PosW = 8;   // walk coordinate width
  localparam int unsigned AccW = 18;  // signed slope accumulator

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic clear;     // clear one map row
    logic accept;    // latch request fields
    logic write;     // store the passable bit of a write request
    logic decode;    // register offsets and directions
    logic mul;       // register products
    logic init;      // load walk registers
    logic kn_rd;     // read the knight-move cell
    logic walk;      // test next cell on the line
    logic ok_set;    // force the result flag
    logic ok_val;
    logic out_load;  // move result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic near;
    logic interior;
    logic knight;
    logic cell_ok;
    logic walk_done;
    logic ok;
    logic out_free;
  } dp_status_t;

endpackage

FILE: design/glos_map.sv
// Passability map: one row word per map row, bit write, row clear, registered read.
module glos_map #(
  parameter int unsigned MapRows = glos_pkg::MapRowsDef,
  parameter int unsigned MapCols = glos_pkg::MapColsDef,
  localparam int unsigned RowAw = $clog2(MapRows),
  localparam int unsigned ColAw = $clog2(MapCols)
) (
  input  logic               clk_i,
  input  logic               clr_en_i,
  input  logic [RowAw-1:0]   clr_row_i,
  input  logic               wr_en_i,
  input  logic [RowAw-1:0]   wr_row_i,
  input  logic [ColAw-1:0]   wr_col_i,
  input  logic               wr_bit_i,
  input  logic               rd_en_i,
  input  logic [RowAw-1:0]   rd_row_i,
  output logic [MapCols-1:0] rd_data_o
);

  logic [MapCols-1:0] mem_q [MapRows];
  logic [MapCols-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (clr_en_i) begin
      mem_q[clr_row_i] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_row_i][wr_col_i] <= wr_bit_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_row_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/glos_dp.sv
// Datapath: request fields, slope setup, line walker, cell check and result register.
`include "grid_line_of_sight_macros.svh"
module glos_dp #(
  parameter int unsigned MapRows = glos_pkg::MapRowsDef,
  parameter int unsigned MapCols = glos_pkg::MapColsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  glos_pkg::ctrl_cmd_t           cmd_i,
  output glos_pkg::dp_status_t          st_o,
  input  logic [glos_pkg::RowW-1:0]     start_row_i,
  input  logic [glos_pkg::ColW-1:0]     start_col_i,
  input  logic [glos_pkg::RowW-1:0]     end_row_i,
  input  logic [glos_pkg::ColW-1:0]     end_col_i,
  input  logic                          passable_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          visible_o
);

  localparam int unsigned RowAw = $clog2(MapRows);
  localparam int unsigned ColAw = $clog2(MapCols);
  localparam int unsigned PosW  = glos_pkg::PosW;
  localparam int unsigned AccW  = glos_pkg::AccW;
  localparam int unsigned RowW  = glos_pkg::RowW;
  localparam int unsigned ColW  = glos_pkg::ColW;
  localparam logic [8:0] RowLast = 9'(MapRows - 2);
  localparam logic [8:0] ColLast = 9'(MapCols - 2);
  localparam logic [8:0] RowCnt  = 9'(MapRows);
  localparam logic [8:0] ColCnt  = 9'(MapCols);
  localparam logic [RowAw-1:0] ClrLast = RowAw'(MapRows - 1);

  function automatic logic [PosW-1:0] stp(input logic [PosW-1:0] v, input logic neg);
    stp = neg ? v - PosW'(1) : v + PosW'(1);
  endfunction

  function automatic logic in_int(input logic [PosW-1:0] r, input logic [PosW-1:0] c);
    in_int = (r != '0) && ({1'b0, r} <= RowLast) && (c != '0) && ({1'b0, c} <= ColLast);
  endfunction

  // request fields
  logic [RowW-1:0] r1_q, r2_q;
  logic [ColW-1:0] c1_q, c2_q;

  // decode
  logic [RowW-1:0] ar_q;
  logic [ColW-1:0] ac_q;
  logic            rneg_q, cneg_q;

  // products
  logic [13:0] half_q;
  logic [15:0] sq_q;
  logic        col_major_q, straight_q;

  // walker
  logic [PosW-1:0]        maj_q, mnr_q, maj_end_q;
  logic                   majneg_q, mnneg_q, ext_q;
  logic signed [AccW-1:0] acc_q, thr_q, sfm_q, step_q;

  // cell check
  logic             chk_q, chk_in_q, ok_q;
  logic [ColAw-1:0] chk_col_q;
  logic [RowAw-1:0] clr_cnt_q;

  logic             out_valid_q, visible_q;

  logic [MapCols-1:0] rd_data;
  logic               cell_ok, walk_done, issue, rd_en, wr_en, gt, eq, cmaj_d, diag;
  logic [PosW-1:0]    row8, col8, row8_in, maj_st, mnr_st, mn;
  logic [RowW-1:0]    ar_d;
  logic [ColW-1:0]    ac_d;
  logic signed [AccW-1:0] half_s, full_s, sq_s, step_s;

  // ---------------- request latch and decode ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      r1_q <= start_row_i;
      c1_q <= start_col_i;
      r2_q <= end_row_i;
      c2_q <= end_col_i;
    end
    if (cmd_i.decode) begin
      ar_q   <= ar_d;
      ac_q   <= ac_d;
      rneg_q <= r2_q < r1_q;
      cneg_q <= c2_q < c1_q;
    end
    if (cmd_i.mul) begin
      half_q      <= {8'd0, ar_q} * {6'd0, ac_q};
      sq_q        <= {8'd0, mn} * {8'd0, mn};
      col_major_q <= cmaj_d;
      straight_q  <= (ar_q == '0) || (ac_q == '0);
    end
  end

  always_comb begin
    ar_d   = (r2_q < r1_q) ? r1_q - r2_q : r2_q - r1_q;
    ac_d   = (c2_q < c1_q) ? c1_q - c2_q : c2_q - c1_q;
    cmaj_d = {2'd0, ar_q} <= ac_q;
    mn     = cmaj_d ? {2'd0, ar_q} : ac_q;
  end

  // ---------------- walker ----------------
  always_comb begin
    half_s = $signed(AccW'(half_q));
    sq_s   = $signed(AccW'(sq_q));
    full_s = half_s <<< 1;
    step_s = sq_s <<< 1;
    maj_st = col_major_q ? c1_q : {2'd0, r1_q};
    mnr_st = col_major_q ? {2'd0, r1_q} : c1_q;
    // exact diagonal: the first step lands on the corner
    diag   = !straight_q && (sq_s == half_s);
    gt     = acc_q > thr_q;
    eq     = acc_q == thr_q;
    walk_done = !ext_q && (maj_q == maj_end_q);
    issue  = cmd_i.walk && !walk_done;
    rd_en  = issue || cmd_i.kn_rd;
    row8   = col_major_q ? mnr_q : maj_q;
    col8   = col_major_q ? maj_q : mnr_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      majneg_q  <= col_major_q ? cneg_q : rneg_q;
      mnneg_q   <= col_major_q ? rneg_q : cneg_q;
      maj_q     <= stp(maj_st, col_major_q ? cneg_q : rneg_q);
      maj_end_q <= col_major_q ? c2_q : {2'd0, r2_q};
      mnr_q     <= diag ? stp(mnr_st, col_major_q ? rneg_q : cneg_q) : mnr_st;
      acc_q     <= diag ? sq_s - full_s : sq_s;
      thr_q     <= half_s - step_s;
      sfm_q     <= step_s - full_s;
      step_q    <= step_s;
    end else if (issue) begin
      if (ext_q || straight_q) begin
        maj_q <= stp(maj_q, majneg_q);
      end else if (gt) begin
        // minor boundary crossed: the extra cell is tested next
        mnr_q <= stp(mnr_q, mnneg_q);
        acc_q <= acc_q + sfm_q;
      end else if (eq) begin
        // corner hit: step diagonally, no extra cell
        mnr_q <= stp(mnr_q, mnneg_q);
        maj_q <= stp(maj_q, majneg_q);
        acc_q <= acc_q + sfm_q;
      end else begin
        maj_q <= stp(maj_q, majneg_q);
        acc_q <= acc_q + step_q;
      end
    end
    if (rd_en) begin
      chk_col_q <= col8[ColAw-1:0];
      chk_in_q  <= in_int(row8, col8);
    end
    if (cmd_i.out_load) begin
      visible_q <= ok_q;
    end
  end

  // ---------------- control-side registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q       <= 1'b0;
      chk_q       <= 1'b0;
      ok_q        <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      chk_q <= issue;
      if (cmd_i.init) begin
        ext_q <= 1'b0;
      end else if (issue) begin
        ext_q <= !ext_q && !straight_q && gt;
      end
      if (cmd_i.ok_set) begin
        ok_q <= cmd_i.ok_val;
      end else if (cmd_i.init) begin
        ok_q <= 1'b1;
      end else if (chk_q && !cell_ok) begin
        ok_q <= 1'b0;
      end
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + RowAw'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- map ----------------
  assign row8_in = {2'd0, start_row_i};
  assign wr_en   = cmd_i.write && ({1'b0, row8_in} < RowCnt) && ({1'b0, start_col_i} < ColCnt);

  glos_map #(
    .MapRows (MapRows),
    .MapCols (MapCols)
  ) u_map (
    .clk_i     (clk_i),
    .clr_en_i  (cmd_i.clear),
    .clr_row_i (clr_cnt_q),
    .wr_en_i   (wr_en),
    .wr_row_i  (row8_in[RowAw-1:0]),
    .wr_col_i  (start_col_i[ColAw-1:0]),
    .wr_bit_i  (passable_i),
    .rd_en_i   (rd_en),
    .rd_row_i  (row8[RowAw-1:0]),
    .rd_data_o (rd_data)
  );

  // border and off-map cells read as blocked
  assign cell_ok = chk_in_q && rd_data[chk_col_q];

  always_comb begin
    st_o.clear_last = clr_cnt_q == ClrLast;
    st_o.near       = (ar_q < RowW'(2)) && (ac_q < ColW'(2));
    st_o.interior   = in_int({2'd0, r1_q}, c1_q);
    st_o.knight     = ((ac_q == ColW'(1)) && (ar_q == RowW'(2))) ||
                      ((ar_q == RowW'(1)) && (ac_q == ColW'(2)));
    st_o.cell_ok    = cell_ok;
    st_o.walk_done  = walk_done;
    st_o.ok         = ok_q;
    st_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;

  // a walk left by a blocked cell may keep ext_q set until the next init
  `GLOS_AIMP(a_ext_sloped, ext_q && cmd_i.walk, !straight_q)
  `GLOS_AIMP(a_no_wr_rd, wr_en || cmd_i.clear, !rd_en)
  `GLOS_ANXT(a_ext_once, ext_q && issue, !ext_q)

endmodule

FILE: design/glos_ctrl.sv
// Controller: map clearing after reset, request sequencing and result hand-off.
`include "grid_line_of_sight_macros.svh"
module glos_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_op_i,
  output logic                 in_ready_o,
  input  glos_pkg::dp_status_t st_i,
  output glos_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    StClear  = 10'b0000000001,
    StIdle   = 10'b0000000010,
    StDecode = 10'b0000000100,
    StMul    = 10'b0000001000,
    StInit   = 10'b0000010000,
    StKnRd   = 10'b0000100000,
    StKnChk  = 10'b0001000000,
    StWalk   = 10'b0010000000,
    StDrain  = 10'b0100000000,
    StDone   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StClear: begin
        cmd_o.clear = 1'b1;
        if (st_i.clear_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_op_i == glos_pkg::OpQuery) begin
            state_d = StDecode;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      StDecode: begin
        cmd_o.decode = 1'b1;
        state_d      = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        if (st_i.near) begin
          cmd_o.ok_set = 1'b1;
          cmd_o.ok_val = 1'b1;
          state_d      = StDone;
        end else if (!st_i.interior) begin
          cmd_o.ok_set = 1'b1;
          cmd_o.ok_val = 1'b0;
          state_d      = StDone;
        end else begin
          state_d = StInit;
        end
      end
      StInit: begin
        cmd_o.init = 1'b1;
        state_d    = st_i.knight ? StKnRd : StWalk;
      end
      StKnRd: begin
        cmd_o.kn_rd = 1'b1;
        state_d     = StKnChk;
      end
      StKnChk: begin
        // open cell beside the start: visible without walking
        state_d = st_i.cell_ok ? StDone : StWalk;
      end
      StWalk: begin
        cmd_o.walk = 1'b1;
        if (st_i.walk_done || !st_i.ok) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StDone;
      end
      StDone: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  `GLOS_AIMP(a_load_free, cmd_o.out_load, st_i.out_free)
  `GLOS_ANXT(a_query_decode, in_valid_i && in_ready_o && (in_op_i == glos_pkg::OpQuery),
             state_q == StDecode)

endmodule

FILE: design/grid_line_of_sight.sv
// Top level of the grid line-of-sight block.
// Holds a MapRows x MapCols map of passable bits and answers line-of-sight
// queries between two cells; border cells always count as blocked. After
// reset the map is cleared one row per cycle, so no request is taken until
// every row is clear. A write request gives no result; writes may follow
// each other every cycle. A query gives one result: near cells and unsafe
// origins are answered without a walk, otherwise one cell is tested per
// cycle (the cells strictly between the ends along the major axis, plus one
// extra cell at each minor-axis crossing); a knight move first checks the
// cell beside the start and ends there when that cell is open. The map has a
// single read port; a walk stops early at the first blocked cell. A finished
// result waits in the output register while the next request is accepted.
module grid_line_of_sight #(
  parameter int unsigned MapRows = glos_pkg::MapRowsDef,
  parameter int unsigned MapCols = glos_pkg::MapColsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // start_row[5:0], start_col[13:6], end_row[19:14], end_col[27:20], passable[28]
  input  logic [31:0] s_axis_tdata,
  // operation[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // visible[0]
  output logic [7:0]  m_axis_tdata
);

  glos_pkg::ctrl_cmd_t  cmd;
  glos_pkg::dp_status_t st;
  logic                 visible;

  glos_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  glos_dp #(
    .MapRows (MapRows),
    .MapCols (MapCols)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .start_row_i (s_axis_tdata[5:0]),
    .start_col_i (s_axis_tdata[13:6]),
    .end_row_i   (s_axis_tdata[19:14]),
    .end_col_i   (s_axis_tdata[27:20]),
    .passable_i  (s_axis_tdata[28]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .visible_o   (visible)
  );

  assign m_axis_tdata = {7'd0, visible};

endmodule

FILE: tb/grid_line_of_sight_tb.sv
// Self-checking testbench for the grid line-of-sight block.
`timescale 1ns / 1ps

module grid_line_of_sight_tb;

  localparam int MapRows       = glos_pkg::MapRowsDef;
  localparam int MapCols       = glos_pkg::MapColsDef;
  localparam int HoldCycles    = 400;
  localparam int DrainCycles   = 300;
  localparam int WatchdogLimit = 4000;
  localparam int RandomItems   = 1375;

  typedef struct {
    bit visible;
    int r1;
    int c1;
    int r2;
    int c2;
  } sight_check_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = glos_pkg::OpWrite;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  // shadow copy of the map as the block should hold it
  bit           open_cells [MapRows][MapCols];
  sight_check_t expected_sight [$];
  int           mismatch_count = 0;
  int           quiet_cycles = 0;
  bit           steady_flow = 1'b0;
  bit           hold_request = 1'b0;

  grid_line_of_sight #(
    .MapRows(MapRows),
    .MapCols(MapCols)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit is_interior(int r, int c);
    return r >= 1 && r <= MapRows - 2 && c >= 1 && c <= MapCols - 2;
  endfunction

  // border and off-map cells read as blocked
  function automatic bit cell_open(int r, int c);
    if (!is_interior(r, c)) return 1'b0;
    return open_cells[r][c];
  endfunction

  function automatic bit predict_visible(int r1, int c1, int r2, int c2);
    int dr, dc, ar, ac, sr, sc;
    int mr, mc, nr, nc, maj_len, min_len;
    int half, full, acc, step, r, c, n;
    dr = r2 - r1;
    dc = c2 - c1;
    ar = (dr < 0) ? -dr : dr;
    ac = (dc < 0) ? -dc : dc;
    if (ar < 2 && ac < 2) return 1'b1;
    if (!is_interior(r1, c1)) return 1'b0;
    sr = (dr < 0) ? -1 : 1;
    sc = (dc < 0) ? -1 : 1;
    if (dc == 0) begin
      for (r = r1 + sr; r != r2; r += sr)
        if (!cell_open(r, c1)) return 1'b0;
      return 1'b1;
    end
    if (dr == 0) begin
      for (c = c1 + sc; c != c2; c += sc)
        if (!cell_open(r1, c)) return 1'b0;
      return 1'b1;
    end
    // knight move: open cell next to the start on the long axis clears it
    if (ac == 1 && ar == 2 && cell_open(r1 + sr, c1)) return 1'b1;
    if (ar == 1 && ac == 2 && cell_open(r1, c1 + sc)) return 1'b1;
    if (ac >= ar) begin
      mr = 0;  mc = sc; nr = sr; nc = 0;
      maj_len = ac; min_len = ar;
    end else begin
      mr = sr; mc = 0;  nr = 0;  nc = sc;
      maj_len = ar; min_len = ac;
    end
    half = ac * ar;
    full = half * 2;
    acc  = min_len * min_len;
    step = acc * 2;
    r = r1 + mr;
    c = c1 + mc;
    if (acc == half) begin
      r += nr; c += nc; acc -= full;
    end
    for (n = 1; n < maj_len; n++) begin
      if (!cell_open(r, c)) return 1'b0;
      acc += step;
      if (acc > half) begin
        r += nr; c += nc;
        if (!cell_open(r, c)) return 1'b0;
        acc -= full;
      end else if (acc == half) begin
        // exact corner: diagonal step, no extra cell
        r += nr; c += nc;
        acc -= full;
      end
      r += mr; c += mc;
    end
    return 1'b1;
  endfunction

  task automatic issue_request(input logic op, input int r1, input int c1,
                               input int r2, input int c2,
                               input logic open_bit);
    sight_check_t chk;
    while (!steady_flow && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, open_bit, 8'(c2), 6'(r2), 8'(c1), 6'(r1)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == glos_pkg::OpWrite) begin
      if (r1 < MapRows && c1 < MapCols) open_cells[r1][c1] = open_bit;
    end else begin
      chk.visible = predict_visible(r1, c1, r2, c2);
      chk.r1 = r1; chk.c1 = c1; chk.r2 = r2; chk.c2 = c2;
      expected_sight.push_back(chk);
    end
  endtask

  task automatic write_cell(input int r, input int c, input logic open_bit);
    issue_request(glos_pkg::OpWrite, r, c, $urandom_range(63), $urandom_range(255), open_bit);
  endtask

  task automatic query_sight(input int r1, input int c1, input int r2, input int c2);
    issue_request(glos_pkg::OpQuery, r1, c1, r2, c2, 1'($urandom_range(1)));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_sight.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_result(input logic [7:0] got);
    sight_check_t chk;
    if (expected_sight.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result, expected none, actual visible %0h", $time, got);
      return;
    end
    chk = expected_sight.pop_front();
    if (got !== {7'b0, chk.visible}) begin
      mismatch_count++;
      $display("%0t: visible mismatch (%0d,%0d)->(%0d,%0d), expected %0h actual %0h",
               $time, chk.r1, chk.c1, chk.r2, chk.c2, {7'b0, chk.visible}, got);
    end
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (steady_flow) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 31);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("grid_line_of_sight regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_directed_cases();
    write_cell(0, 0, 1'b1);
    write_cell(63, 255, 1'b1);
    query_sight(0, 0, 0, 0);        // identical cells
    query_sight(63, 255, 62, 254);  // adjacent cells
    query_sight(0, 5, 3, 9);        // origin on the border
    query_sight(63, 255, 60, 250);
    write_cell(10, 20, 1'b1);
    write_cell(11, 20, 1'b1);
    query_sight(9, 20, 12, 20);
    query_sight(9, 20, 13, 20);
    write_cell(10, 21, 1'b1);
    query_sight(10, 19, 10, 22);
    write_cell(20, 31, 1'b1);
    query_sight(20, 30, 21, 32);    // knight, near cell open
    query_sight(30, 30, 32, 31);    // knight, falls to the walk
    write_cell(41, 41, 1'b1);
    query_sight(40, 40, 42, 42);    // diagonal hits corners exactly
    write_cell(1, 6, 1'b1);
    write_cell(1, 7, 1'b1);
    write_cell(0, 7, 1'b1);         // stored, still reads blocked
    query_sight(1, 5, 0, 9);
    write_cell(5, 5, 1'b0);
    query_sight(62, 254, 1, 1);
    query_sight(1, 1, 62, 254);
    wait_drained();
  endtask

  task automatic test_long_lines();
    steady_flow = 1'b1;
    for (int c = 1; c <= MapCols - 2; c++) begin
      write_cell(1, c, 1'b1);
      write_cell(2, c, 1'b1);
    end
    for (int r = 1; r <= MapRows - 2; r++) write_cell(r, 5, 1'b1);
    steady_flow = 1'b0;
    query_sight(1, 1, 1, 255);
    query_sight(2, 254, 2, 0);
    query_sight(2, 1, 1, 255);
    query_sight(1, 254, 2, 0);
    query_sight(2, 254, 1, 1);
    query_sight(1, 1, 2, 200);
    query_sight(1, 5, 63, 5);
    query_sight(62, 5, 0, 5);
    query_sight(1, 5, 63, 6);
    query_sight(62, 5, 0, 4);
    for (int i = 0; i < 10; i++)
      query_sight($urandom_range(1, 2), $urandom_range(1, 254),
                  $urandom_range(0, 3), $urandom_range(255));
    wait_drained();
  endtask

  // sink holds off while requests keep coming, then the sender waits out the backlog
  task automatic test_backpressure();
    hold_request = 1'b1;
    for (int i = 0; i < 12; i++)
      query_sight($urandom_range(1, 2), $urandom_range(1, 40),
                  $urandom_range(1, 2), $urandom_range(1, 40));
    wait_drained();
  endtask

  task automatic test_random_mix();
    int pick;
    for (int i = 0; i < RandomItems; i++) begin
      steady_flow = (i >= 800 && i < 1100);
      pick = $urandom_range(99);
      if (pick < 28) begin
        write_cell($urandom_range(0, 12), $urandom_range(0, 40), $urandom_range(99) < 85);
      end else if (pick < 35) begin
        write_cell($urandom_range(63), $urandom_range(255), 1'($urandom_range(1)));
      end else if (pick < 80) begin
        query_sight($urandom_range(0, 12), $urandom_range(0, 40),
                    $urandom_range(0, 12), $urandom_range(0, 40));
      end else if (pick < 88) begin
        query_sight($urandom_range(1, 2), $urandom_range(1, 254),
                    $urandom_range(1, 2), $urandom_range(255));
      end else begin
        query_sight($urandom_range(63), $urandom_range(255),
                    $urandom_range(63), $urandom_range(255));
      end
    end
    steady_flow = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_long_lines();
    test_backpressure();
    test_random_mix();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_sight.size() == 0) begin
      $display("grid_line_of_sight regression: pass");
    end else begin
      $display("grid_line_of_sight regression: fail");
    end
    $finish;
  end

endmodule

FILE: grid_line_of_sight.f
+incdir+design
design/glos_pkg.sv
design/glos_map.sv
design/glos_dp.sv
design/glos_ctrl.sv
design/grid_line_of_sight.sv
tb/grid_line_of_sight_tb.sv
